/* rtl/cbps_pkg.sv */
// Shared constants, control word layout, microprogram and division table for the Bezier smoother.
package cbps_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int MAX_SEGMENTS = 32;
  localparam int SEG_W        = 6;
  localparam int J_W          = $clog2(MAX_SEGMENTS);
  localparam int FRAC         = 16;
  localparam int T_W          = FRAC + 1;
  localparam int MA_W         = ((COORD_WIDTH > 2 * FRAC + 1) ? COORD_WIDTH : 2 * FRAC + 1) + 1;
  localparam int MB_W         = T_W + 1;
  localparam int P_W          = MA_W + MB_W;
  localparam int WGT_LSB      = 2 * FRAC;
  localparam int ADDR_W       = 5;
  localparam logic [SEG_W-1:0] SEG_RESET = 6'd10;

  // Multiplier A operand selects.
  localparam logic [3:0] A_U   = 4'd0;
  localparam logic [3:0] A_T   = 4'd1;
  localparam logic [3:0] A_UU  = 4'd2;
  localparam logic [3:0] A_TT  = 4'd3;
  localparam logic [3:0] A_GX0 = 4'd4;
  localparam logic [3:0] A_GX1 = 4'd5;
  localparam logic [3:0] A_GX2 = 4'd6;
  localparam logic [3:0] A_PX  = 4'd7;
  localparam logic [3:0] A_GY0 = 4'd8;
  localparam logic [3:0] A_GY1 = 4'd9;
  localparam logic [3:0] A_GY2 = 4'd10;
  localparam logic [3:0] A_PY  = 4'd11;

  // Multiplier B operand selects.
  localparam logic [2:0] B_U  = 3'd0;
  localparam logic [2:0] B_T  = 3'd1;
  localparam logic [2:0] B_W0 = 3'd2;
  localparam logic [2:0] B_W1 = 3'd3;
  localparam logic [2:0] B_W2 = 3'd4;
  localparam logic [2:0] B_W3 = 3'd5;

  // Destinations for the registered product.
  localparam logic [3:0] WB_NONE     = 4'd0;
  localparam logic [3:0] WB_UU       = 4'd1;
  localparam logic [3:0] WB_TT       = 4'd2;
  localparam logic [3:0] WB_W0       = 4'd3;
  localparam logic [3:0] WB_W1       = 4'd4;
  localparam logic [3:0] WB_W2       = 4'd5;
  localparam logic [3:0] WB_W3       = 4'd6;
  localparam logic [3:0] WB_ACCX_LD  = 4'd7;
  localparam logic [3:0] WB_ACCX_ADD = 4'd8;
  localparam logic [3:0] WB_ACCY_LD  = 4'd9;
  localparam logic [3:0] WB_ACCY_ADD = 4'd10;

  // Output word sources.
  localparam logic [1:0] EMIT_NONE  = 2'd0;
  localparam logic [1:0] EMIT_CURVE = 2'd1;
  localparam logic [1:0] EMIT_GROUP = 2'd2;
  localparam logic [1:0] EMIT_POINT = 2'd3;

  // Jump conditions.
  localparam logic [2:0] C_NEXT         = 3'd0;
  localparam logic [2:0] C_ALWAYS       = 3'd1;
  localparam logic [2:0] C_MORE_SAMPLES = 3'd2;
  localparam logic [2:0] C_MORE_BUF     = 3'd3;
  localparam logic [2:0] C_BUF_EMPTY    = 3'd4;
  localparam logic [2:0] C_DISPATCH     = 3'd5;

  // Program addresses that are jumped to.
  localparam logic [ADDR_W-1:0] ADDR_IDLE      = 5'd0;
  localparam logic [ADDR_W-1:0] ADDR_SETUP     = 5'd1;
  localparam logic [ADDR_W-1:0] ADDR_SAMPLE    = 5'd2;
  localparam logic [ADDR_W-1:0] ADDR_PASS      = 5'd19;
  localparam logic [ADDR_W-1:0] ADDR_PASS_LOOP = 5'd20;
  localparam logic [ADDR_W-1:0] ADDR_PASS_LAST = 5'd21;

  typedef struct packed {
    logic              take;
    logic              init;
    logic [2:0]        cond;
    logic [ADDR_W-1:0] target;
    logic [3:0]        a_sel;
    logic [2:0]        b_sel;
    logic [3:0]        wb;
    logic [1:0]        emit;
  } ctrl_t;

  typedef struct packed {
    logic go_curve;
    logic go_pass;
    logic more_samples;
    logic more_buf;
    logic buf_empty;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [T_W-1:0]   q0;
    logic [J_W-1:0]   r0;
  } step_t;

  function automatic ctrl_t cw(input logic take, input logic init, input logic [2:0] cond,
                               input logic [ADDR_W-1:0] target, input logic [3:0] a_sel,
                               input logic [2:0] b_sel, input logic [3:0] wb,
                               input logic [1:0] emit);
    ctrl_t w;
    w.take   = take;
    w.init   = init;
    w.cond   = cond;
    w.target = target;
    w.a_sel  = a_sel;
    w.b_sel  = b_sel;
    w.wb     = wb;
    w.emit   = emit;
    return w;
  endfunction

  // Dispatch, samples (u,t weights on the shared multiplier, then x and y blends), pass-through.
  function automatic ctrl_t rom_word(input logic [ADDR_W-1:0] addr);
    ctrl_t w;
    case (addr)
      5'd0:  w = cw(1'b1, 1'b0, C_DISPATCH, ADDR_IDLE, A_U, B_U, WB_NONE, EMIT_NONE);
      5'd1:  w = cw(1'b0, 1'b1, C_NEXT, ADDR_IDLE, A_U, B_U, WB_NONE, EMIT_NONE);
      5'd2:  w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_U, B_U, WB_NONE, EMIT_NONE);
      5'd3:  w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_T, B_T, WB_UU, EMIT_NONE);
      5'd4:  w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_UU, B_U, WB_TT, EMIT_NONE);
      5'd5:  w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_UU, B_T, WB_W0, EMIT_NONE);
      5'd6:  w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_TT, B_U, WB_W1, EMIT_NONE);
      5'd7:  w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_TT, B_T, WB_W2, EMIT_NONE);
      5'd8:  w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_GX0, B_W0, WB_W3, EMIT_NONE);
      5'd9:  w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_GX1, B_W1, WB_ACCX_LD, EMIT_NONE);
      5'd10: w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_GX2, B_W2, WB_ACCX_ADD, EMIT_NONE);
      5'd11: w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_PX, B_W3, WB_ACCX_ADD, EMIT_NONE);
      5'd12: w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_GY0, B_W0, WB_ACCX_ADD, EMIT_NONE);
      5'd13: w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_GY1, B_W1, WB_ACCY_LD, EMIT_NONE);
      5'd14: w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_GY2, B_W2, WB_ACCY_ADD, EMIT_NONE);
      5'd15: w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_PY, B_W3, WB_ACCY_ADD, EMIT_NONE);
      5'd16: w = cw(1'b0, 1'b0, C_NEXT, ADDR_IDLE, A_U, B_U, WB_ACCY_ADD, EMIT_NONE);
      5'd17: w = cw(1'b0, 1'b0, C_MORE_SAMPLES, ADDR_SAMPLE, A_U, B_U, WB_NONE, EMIT_CURVE);
      5'd18: w = cw(1'b0, 1'b0, C_ALWAYS, ADDR_IDLE, A_U, B_U, WB_NONE, EMIT_NONE);
      5'd19: w = cw(1'b0, 1'b0, C_BUF_EMPTY, ADDR_PASS_LAST, A_U, B_U, WB_NONE, EMIT_NONE);
      5'd20: w = cw(1'b0, 1'b0, C_MORE_BUF, ADDR_PASS_LOOP, A_U, B_U, WB_NONE, EMIT_GROUP);
      5'd21: w = cw(1'b0, 1'b0, C_ALWAYS, ADDR_IDLE, A_U, B_U, WB_NONE, EMIT_POINT);
      default: w = cw(1'b0, 1'b0, C_ALWAYS, ADDR_IDLE, A_U, B_U, WB_NONE, EMIT_NONE);
    endcase
    return w;
  endfunction

  // Quotient and remainder of 65536 by the sample count, used to step t without a divider.
  function automatic step_t div_entry(input logic [SEG_W-1:0] n);
    step_t s;
    case (n)
      6'd1:  s = '{q0: 17'd65536, r0: 5'd0};
      6'd2:  s = '{q0: 17'd32768, r0: 5'd0};
      6'd3:  s = '{q0: 17'd21845, r0: 5'd1};
      6'd4:  s = '{q0: 17'd16384, r0: 5'd0};
      6'd5:  s = '{q0: 17'd13107, r0: 5'd1};
      6'd6:  s = '{q0: 17'd10922, r0: 5'd4};
      6'd7:  s = '{q0: 17'd9362,  r0: 5'd2};
      6'd8:  s = '{q0: 17'd8192,  r0: 5'd0};
      6'd9:  s = '{q0: 17'd7281,  r0: 5'd7};
      6'd10: s = '{q0: 17'd6553,  r0: 5'd6};
      6'd11: s = '{q0: 17'd5957,  r0: 5'd9};
      6'd12: s = '{q0: 17'd5461,  r0: 5'd4};
      6'd13: s = '{q0: 17'd5041,  r0: 5'd3};
      6'd14: s = '{q0: 17'd4681,  r0: 5'd2};
      6'd15: s = '{q0: 17'd4369,  r0: 5'd1};
      6'd16: s = '{q0: 17'd4096,  r0: 5'd0};
      6'd17: s = '{q0: 17'd3855,  r0: 5'd1};
      6'd18: s = '{q0: 17'd3640,  r0: 5'd16};
      6'd19: s = '{q0: 17'd3449,  r0: 5'd5};
      6'd20: s = '{q0: 17'd3276,  r0: 5'd16};
      6'd21: s = '{q0: 17'd3120,  r0: 5'd16};
      6'd22: s = '{q0: 17'd2978,  r0: 5'd20};
      6'd23: s = '{q0: 17'd2849,  r0: 5'd9};
      6'd24: s = '{q0: 17'd2730,  r0: 5'd16};
      6'd25: s = '{q0: 17'd2621,  r0: 5'd11};
      6'd26: s = '{q0: 17'd2520,  r0: 5'd16};
      6'd27: s = '{q0: 17'd2427,  r0: 5'd7};
      6'd28: s = '{q0: 17'd2340,  r0: 5'd16};
      6'd29: s = '{q0: 17'd2259,  r0: 5'd25};
      6'd30: s = '{q0: 17'd2184,  r0: 5'd16};
      6'd31: s = '{q0: 17'd2114,  r0: 5'd2};
      6'd32: s = '{q0: 17'd2048,  r0: 5'd0};
      default: s = '{q0: 17'd65536, r0: 5'd0};
    endcase
    return s;
  endfunction

endpackage

/* rtl/cbps_ifs.sv */
// Handshake channel interfaces for points in, points out and the segment-count register.
interface cbps_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cbps_pkg::COORD_WIDTH-1:0] point_x;
  logic signed [cbps_pkg::COORD_WIDTH-1:0] point_y;
  logic                                  path_end;
  modport source (output valid, point_x, point_y, path_end, input ready);
  modport sink (input valid, point_x, point_y, path_end, output ready);
endinterface

interface cbps_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cbps_pkg::COORD_WIDTH-1:0] out_x;
  logic signed [cbps_pkg::COORD_WIDTH-1:0] out_y;
  logic                                  from_curve;
  logic                                  last_of_run;
  modport source (output valid, out_x, out_y, from_curve, last_of_run, input ready);
  modport sink (input valid, out_x, out_y, from_curve, last_of_run, output ready);
endinterface

interface cbps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cbps_pkg::SEG_W-1:0]      data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/cbps_sequencer.sv */
// Microprogram step counter: reads the control word and chooses the next step.
module cbps_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  cbps_pkg::status_t st,
  output cbps_pkg::ctrl_t   word,
  output logic              fire,
  output logic              in_ready
);

  logic [cbps_pkg::ADDR_W-1:0] addr;
  logic [cbps_pkg::ADDR_W-1:0] addr_next;
  logic                        branch;

  assign word     = cbps_pkg::rom_word(addr);
  assign in_ready = word.take && !rst;
  // A step holds while it waits for a point or for room in the output register.
  assign fire = !(word.take && !(in_valid && in_ready)) &&
                !((word.emit != cbps_pkg::EMIT_NONE) && !st.out_free);

  always_comb begin
    case (word.cond)
      cbps_pkg::C_NEXT:         branch = 1'b0;
      cbps_pkg::C_ALWAYS:       branch = 1'b1;
      cbps_pkg::C_MORE_SAMPLES: branch = st.more_samples;
      cbps_pkg::C_MORE_BUF:     branch = st.more_buf;
      cbps_pkg::C_BUF_EMPTY:    branch = st.buf_empty;
      default:                  branch = 1'b0;
    endcase
    if (!fire) begin
      addr_next = addr;
    end else if (word.cond == cbps_pkg::C_DISPATCH) begin
      if (st.go_curve) begin
        addr_next = cbps_pkg::ADDR_SETUP;
      end else if (st.go_pass) begin
        addr_next = cbps_pkg::ADDR_PASS;
      end else begin
        addr_next = cbps_pkg::ADDR_IDLE;
      end
    end else if (branch) begin
      addr_next = word.target;
    end else begin
      addr_next = addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= cbps_pkg::ADDR_IDLE;
    end else begin
      addr <= addr_next;
    end
  end

  a_point_ends_run: assert property (@(posedge clk) disable iff (rst)
    fire && word.emit == cbps_pkg::EMIT_POINT |=> addr == cbps_pkg::ADDR_IDLE)
    else $error("sequencer did not return to idle after the final pass-through word");

  a_full_group_starts_curve: assert property (@(posedge clk) disable iff (rst)
    fire && word.take && st.go_curve |=> addr == cbps_pkg::ADDR_SETUP)
    else $error("fourth point of a group did not start the curve program");

endmodule

/* rtl/cbps_datapath.sv */
// Datapath: group buffer, t stepping, shared multiplier, accumulators and output register.
module cbps_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cbps_pkg::ctrl_t                        word,
  input  logic                                   fire,
  input  logic signed [cbps_pkg::COORD_WIDTH-1:0] in_x,
  input  logic signed [cbps_pkg::COORD_WIDTH-1:0] in_y,
  input  logic                                   in_end,
  cbps_cfg_if.sink                               cfg,
  cbps_out_if.source                             pt_out,
  output cbps_pkg::status_t                      st
);

  localparam int CW = cbps_pkg::COORD_WIDTH;
  localparam int TW = cbps_pkg::T_W;
  localparam int JW = cbps_pkg::J_W;
  localparam int SW = cbps_pkg::SEG_W;
  localparam int PW = cbps_pkg::P_W;
  localparam int AW = cbps_pkg::MA_W;
  localparam int BW = cbps_pkg::MB_W;
  localparam int WL = cbps_pkg::WGT_LSB;
  localparam int FR = cbps_pkg::FRAC;

  logic [SW-1:0]        seg;
  logic [1:0]           fill;
  logic signed [CW-1:0] gx [3];
  logic signed [CW-1:0] gy [3];
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic [1:0]           pass_count;
  logic [1:0]           k;
  logic [SW-1:0]        n;
  logic [SW-1:0]        n_sel;
  cbps_pkg::step_t      stp;
  logic [TW-1:0]        t;
  logic [TW-1:0]        u;
  logic [JW-1:0]        rem;
  logic [JW:0]          rem_sum;
  logic                 carry;
  logic [JW-1:0]        j;
  logic [2*FR:0]        uu;
  logic [2*FR-1:0]      tt;
  logic [TW-1:0]        w0;
  logic [TW-1:0]        w1;
  logic [TW-1:0]        w2;
  logic [TW-1:0]        w3;
  logic signed [AW-1:0] ma;
  logic signed [BW-1:0] mb;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod3;
  logic signed [PW-1:0] acc_x;
  logic signed [PW-1:0] acc_y;
  logic                 o_valid;
  logic signed [CW-1:0] o_x;
  logic signed [CW-1:0] o_y;
  logic                 o_curve;
  logic                 o_last;
  logic [TW+1:0]        wsum;

  assign cfg.ready = !rst;

  assign pt_out.valid       = o_valid;
  assign pt_out.out_x       = o_x;
  assign pt_out.out_y       = o_y;
  assign pt_out.from_curve  = o_curve;
  assign pt_out.last_of_run = o_last;

  assign st.go_curve     = (fill == 2'd3);
  assign st.go_pass      = in_end;
  assign st.more_samples = ({1'b0, j} != (n - 1'b1));
  assign st.more_buf     = ((k + 2'd1) != pass_count);
  assign st.buf_empty    = (pass_count == 2'd0);
  assign st.out_free     = !o_valid || pt_out.ready;

  always_comb begin
    if (seg == '0) begin
      n_sel = SW'(1);
    end else if (seg > SW'(cbps_pkg::MAX_SEGMENTS)) begin
      n_sel = SW'(cbps_pkg::MAX_SEGMENTS);
    end else begin
      n_sel = seg;
    end
  end

  // The step comes from the latched count, so a register write mid-run cannot disturb t.
  assign stp     = cbps_pkg::div_entry(n);
  assign u       = TW'(1 << FR) - t;
  // rem and r0 are both below n, so one compare and subtract keeps t exact.
  assign rem_sum = {1'b0, rem} + {1'b0, stp.r0};
  assign carry   = (rem_sum >= (JW + 1)'(n));
  assign prod3   = prod + (prod <<< 1);
  assign wsum    = {2'b00, w0} + {2'b00, w1} + {2'b00, w2} + {2'b00, w3};

  always_comb begin
    case (word.a_sel)
      cbps_pkg::A_U:   ma = AW'(u);
      cbps_pkg::A_T:   ma = AW'(t);
      cbps_pkg::A_UU:  ma = AW'(uu);
      cbps_pkg::A_TT:  ma = AW'(tt);
      cbps_pkg::A_GX0: ma = AW'(gx[0]);
      cbps_pkg::A_GX1: ma = AW'(gx[1]);
      cbps_pkg::A_GX2: ma = AW'(gx[2]);
      cbps_pkg::A_PX:  ma = AW'(px);
      cbps_pkg::A_GY0: ma = AW'(gy[0]);
      cbps_pkg::A_GY1: ma = AW'(gy[1]);
      cbps_pkg::A_GY2: ma = AW'(gy[2]);
      cbps_pkg::A_PY:  ma = AW'(py);
      default:         ma = '0;
    endcase
    case (word.b_sel)
      cbps_pkg::B_U:  mb = BW'(u);
      cbps_pkg::B_T:  mb = BW'(t);
      cbps_pkg::B_W0: mb = BW'(w0);
      cbps_pkg::B_W1: mb = BW'(w1);
      cbps_pkg::B_W2: mb = BW'(w2);
      cbps_pkg::B_W3: mb = BW'(w3);
      default:        mb = '0;
    endcase
  end

  // Unsigned operands go in zero-extended; coordinates are sign-extended by the casts.
  always_ff @(posedge clk) begin
    if (fire) begin
      prod <= ma * mb;
      case (word.wb)
        cbps_pkg::WB_NONE:     ;
        cbps_pkg::WB_UU:       uu <= prod[2*FR:0];
        cbps_pkg::WB_TT:       tt <= prod[2*FR-1:0];
        cbps_pkg::WB_W0:       w0 <= prod[WL+TW-1:WL];
        cbps_pkg::WB_W1:       w1 <= prod3[WL+TW-1:WL];
        cbps_pkg::WB_W2:       w2 <= prod3[WL+TW-1:WL];
        cbps_pkg::WB_W3:       w3 <= prod[WL+TW-1:WL];
        cbps_pkg::WB_ACCX_LD:  acc_x <= prod;
        cbps_pkg::WB_ACCX_ADD: acc_x <= acc_x + prod;
        cbps_pkg::WB_ACCY_LD:  acc_y <= prod;
        cbps_pkg::WB_ACCY_ADD: acc_y <= acc_y + prod;
        default:               ;
      endcase
    end
  end

  // Group buffer and the point that set off the current run.
  always_ff @(posedge clk) begin
    if (fire && word.take) begin
      px <= in_x;
      py <= in_y;
      if ((fill != 2'd3) && !in_end) begin
        gx[fill] <= in_x;
        gy[fill] <= in_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= 2'd0;
      pass_count <= 2'd0;
      k          <= 2'd0;
    end else if (fire && word.take) begin
      k <= 2'd0;
      if (fill == 2'd3) begin
        fill <= 2'd0;
      end else if (in_end) begin
        pass_count <= fill;
        fill       <= 2'd0;
      end else begin
        fill <= fill + 2'd1;
      end
    end else if (fire && (word.emit == cbps_pkg::EMIT_GROUP)) begin
      k <= k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= cbps_pkg::SEG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      seg <= cfg.data;
    end
  end

  // Sample position: t steps by 65536/n with the remainder carried along.
  always_ff @(posedge clk) begin
    if (rst) begin
      n   <= SW'(1);
      rem <= '0;
    end else if (fire && word.init) begin
      n   <= n_sel;
      rem <= '0;
    end else if (fire && (word.emit == cbps_pkg::EMIT_CURVE)) begin
      rem <= carry ? JW'(rem_sum - (JW + 1)'(n)) : JW'(rem_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && word.init) begin
      t <= '0;
      j <= '0;
    end else if (fire && (word.emit == cbps_pkg::EMIT_CURVE)) begin
      t <= t + stp.q0 + TW'(carry);
      j <= j + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fire && (word.emit != cbps_pkg::EMIT_NONE)) begin
      o_valid <= 1'b1;
    end else if (pt_out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      case (word.emit)
        cbps_pkg::EMIT_NONE: ;
        cbps_pkg::EMIT_CURVE: begin
          o_x     <= acc_x[FR+CW-1:FR];
          o_y     <= acc_y[FR+CW-1:FR];
          o_curve <= 1'b1;
          o_last  <= !st.more_samples;
        end
        cbps_pkg::EMIT_GROUP: begin
          o_x     <= gx[k];
          o_y     <= gy[k];
          o_curve <= 1'b0;
          o_last  <= 1'b0;
        end
        cbps_pkg::EMIT_POINT: begin
          o_x     <= px;
          o_y     <= py;
          o_curve <= 1'b0;
          o_last  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_fill_clears: assert property (@(posedge clk) disable iff (rst)
    fire && word.take && fill == 2'd3 |=> fill == 2'd0)
    else $error("group fill not cleared after a full group");

  a_weights_bounded: assert property (@(posedge clk) disable iff (rst)
    fire && word.emit == cbps_pkg::EMIT_CURVE |-> wsum <= (TW + 2)'(1 << FR))
    else $error("Bezier weights sum above one");

  a_rem_below_n: assert property (@(posedge clk) disable iff (rst)
    (JW + 1)'(rem) < (JW + 1)'(n))
    else $error("t remainder not below the sample count");

endmodule

/* rtl/cubic_bezier_path_smoother.sv */
// Top level of the cubic Bezier path smoother: sequencer, datapath and channel hookup.
// Points (signed Q16.16) are taken on pt_in one per cycle while the block is at its idle
// step. A point that only joins the current group gives no word. The fourth point of a
// group starts a run of n samples, where n is segments_per_group clamped to 1..32: each
// sample is fifteen steps on the one 34x18 multiplier (four weights from u and t, then
// four products each for x and y into two accumulators) plus one step that loads the
// output register. A path-end point that finds k < 3 points buffered sends k + 1 words
// unchanged. Every result word passes through one output register, so a stalled pt_out
// holds the program only at its output steps. The segment count is written on cfg, which
// is ready whenever reset is low, and takes effect at the next full group.
module cubic_bezier_path_smoother (
  input  logic       clk,
  input  logic       rst,
  cbps_in_if.sink    pt_in,
  cbps_out_if.source pt_out,
  cbps_cfg_if.sink   cfg
);

  cbps_pkg::ctrl_t   word;
  cbps_pkg::status_t st;
  logic              fire;
  logic              seq_ready;

  assign pt_in.ready = seq_ready;

  cbps_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pt_in.valid),
    .st       (st),
    .word     (word),
    .fire     (fire),
    .in_ready (seq_ready)
  );

  cbps_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .word   (word),
    .fire   (fire),
    .in_x   (pt_in.point_x),
    .in_y   (pt_in.point_y),
    .in_end (pt_in.path_end),
    .cfg    (cfg),
    .pt_out (pt_out),
    .st     (st)
  );

endmodule
